// ===== src/htfd_pkg.sv =====
// Shared types, constants and functions of the humidity/temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam int POS_W = 3;
   localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
   localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
   localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

   localparam int TEMP_W      = 15;
   localparam int HUM_W       = 14;
   localparam int WORD_W      = 16;
   localparam int TEMP_PROD_W = 31;
   localparam int HUM_PROD_W  = 30;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
   localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;
   localparam logic signed [15:0] HUM_MAX     = 16'sd10000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } htfd_req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic [HUM_W-1:0]         humidity_centi;
      logic [WORD_W-1:0]        temp_raw;
      logic [WORD_W-1:0]        hum_raw;
      logic                     status;
   } htfd_rsp_type;

   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 32768 * 65535: one fold and one correction
   function automatic logic [14:0] div65535(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = x[30:16];
      r  = {1'b0, x[15:0]} + {2'b0, q0};
      return (r >= 17'd65535) ? q0 + 15'd1 : q0;
   endfunction

endpackage

// ===== src/humidity_temp_frame_decoder.sv =====
// Humidity/temperature frame decoder top level.
// Takes one byte per cycle when not stalled: temperature word, its CRC-8, humidity word,
// its CRC-8 (polynomial 0x31, start 0xFF, per word). frame_start restarts the byte count;
// without it frames follow back to back. The sixth byte yields one result beat in the
// next cycle, with the converted values (status 0) or, on a CRC mismatch, the last good
// values (status 1). The scale products are formed when each word completes and the
// divide and clamp run on the last byte. While a result beat waits under rsp_stall,
// bytes keep flowing until the byte count reaches the sixth position.
module humidity_temp_frame_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  htfd_pkg::htfd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output htfd_pkg::htfd_rsp_type rsp_data
);
   import htfd_pkg::*;

   logic [POS_W-1:0]         pos_ff, pos_in, pos_eff;
   logic [7:0]               crc_ff, crc_in;
   logic [7:0]               high_ff, high_in;
   logic [WORD_W-1:0]        temp_word_ff, temp_word_in;
   logic [WORD_W-1:0]        hum_word_ff, hum_word_in;
   logic                     temp_ok_ff, temp_ok_in;
   logic [TEMP_PROD_W-1:0]   temp_prod_ff, temp_prod_in;
   logic [HUM_PROD_W-1:0]    hum_prod_ff, hum_prod_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;
   logic [HUM_W-1:0]         last_hum_ff, last_hum_in;
   htfd_rsp_type             rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     accept;
   logic                     ok;
   logic [WORD_W-1:0]        word;
   logic signed [TEMP_W-1:0] conv_temp;
   logic [HUM_W-1:0]         conv_hum;

   htfd_convert u_convert (
      .temp_prod   (temp_prod_ff),
      .hum_prod    (hum_prod_ff),
      .temperature (conv_temp),
      .humidity    (conv_hum)
   );

   assign req_stall = rsp_valid_ff && rsp_stall && (pos_ff == POS_H_CRC);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      pos_eff = pos_ff;
      if (req_data.frame_start || pos_ff > POS_H_CRC) begin
         pos_eff = POS_T_HI;
      end
      word = {high_ff, req_data.data_byte};
      ok   = temp_ok_ff && (crc_ff == req_data.data_byte);

      pos_in       = pos_ff;
      crc_in       = crc_ff;
      high_in      = high_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_ok_in   = temp_ok_ff;
      temp_prod_in = temp_prod_ff;
      hum_prod_in  = hum_prod_ff;
      last_temp_in = last_temp_ff;
      last_hum_in  = last_hum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         case (pos_eff) inside
            POS_T_HI, POS_H_HI: begin
               crc_in  = crc8_feed(CRC_INIT, req_data.data_byte);
               high_in = req_data.data_byte;
               pos_in  = pos_eff + 3'd1;
            end
            POS_T_LO: begin
               crc_in       = crc8_feed(crc_ff, req_data.data_byte);
               temp_word_in = word;
               temp_prod_in = {16'b0, TEMP_SCALE} * {15'b0, word};
               pos_in       = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_ok_in = (crc_ff == req_data.data_byte);
               crc_in     = CRC_INIT;
               pos_in     = POS_H_HI;
            end
            POS_H_LO: begin
               crc_in      = crc8_feed(crc_ff, req_data.data_byte);
               hum_word_in = word;
               hum_prod_in = {16'b0, HUM_SCALE} * {14'b0, word};
               pos_in      = POS_H_CRC;
            end
            default: begin
               crc_in = CRC_INIT;
               pos_in = POS_T_HI;
               if (ok) begin
                  last_temp_in = conv_temp;
                  last_hum_in  = conv_hum;
               end
               rsp_in.temperature_centi = ok ? conv_temp : last_temp_ff;
               rsp_in.humidity_centi    = ok ? conv_hum : last_hum_ff;
               rsp_in.temp_raw          = temp_word_ff;
               rsp_in.hum_raw           = hum_word_ff;
               rsp_in.status            = !ok;
               rsp_valid_in             = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= CRC_INIT;
         high_ff      <= '0;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         temp_ok_ff   <= 1'b0;
         last_temp_ff <= '0;
         last_hum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         high_ff      <= high_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_ok_ff   <= temp_ok_in;
         last_temp_ff <= last_temp_in;
         last_hum_ff  <= last_hum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_prod_ff <= temp_prod_in;
      hum_prod_ff  <= hum_prod_in;
      rsp_ff       <= rsp_in;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_H_CRC)
      else $error("byte position out of range");

   a_hum_clamped: assert property (@(posedge clock) disable iff (reset)
      last_hum_ff <= HUM_MAX[HUM_W-1:0])
      else $error("stored humidity above clamp");

   a_rsp_last_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.temperature_centi == last_temp_ff)
                       && (rsp_ff.humidity_centi == last_hum_ff))
      else $error("result beat disagrees with stored values");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.frame_start && pos_ff == POS_H_CRC
      |=> rsp_valid_ff && pos_ff == POS_T_HI)
      else $error("sixth byte did not produce a result beat");

endmodule

// ===== src/htfd_convert.sv =====
// Scaled-product to centi-unit conversion with offset and humidity clamp.
module htfd_convert (
   input  logic [htfd_pkg::TEMP_PROD_W-1:0]   temp_prod,
   input  logic [htfd_pkg::HUM_PROD_W-1:0]    hum_prod,
   output logic signed [htfd_pkg::TEMP_W-1:0] temperature,
   output logic [htfd_pkg::HUM_W-1:0]         humidity
);
   import htfd_pkg::*;

   logic [14:0]        temp_q;
   logic [14:0]        hum_q;
   logic signed [15:0] temp_s;
   logic signed [15:0] hum_s;

   always_comb begin
      temp_q = div65535(temp_prod);
      hum_q  = div65535({1'b0, hum_prod});
      temp_s = signed'({1'b0, temp_q}) - TEMP_OFFSET;
      hum_s  = signed'({1'b0, hum_q}) - HUM_OFFSET;
      temperature = temp_s[TEMP_W-1:0];
      if (hum_s < 16'sd0) begin
         humidity = '0;
      end else if (hum_s > HUM_MAX) begin
         humidity = HUM_MAX[HUM_W-1:0];
      end else begin
         humidity = hum_s[HUM_W-1:0];
      end
   end

endmodule
